@@ hw/rtl/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // Built capacity of the pool and derived widths
  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  // Fixed field widths
  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 17;
  localparam int BCNT_W     = 7;
  localparam int BIDX_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int DIV_CNT_W  = $clog2(ADDR_W);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

  // Reset values of the configuration registers
  localparam logic [ADDR_W-1:0] POOL_BASE_RST   = '0;
  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST  = 17'd16;
  localparam logic [BCNT_W-1:0] BLOCK_COUNT_RST = 7'd64;

  // Request operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic              success;
    logic [ADDR_W-1:0] block_address;
    logic [BIDX_W-1:0] block_index;
  } res_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic claim;
    logic set_addr;
    logic div_step;
    logic commit_free;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic n_zero;
    logic cur_free;
    logic scan_last;
    logic div_last;
  } stat_t;

endpackage

@@ hw/rtl/fbpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Sequencer of the allocator: steps the scan, the divider and the result.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           operation,
  input  fbpa_pkg::stat_t stat,
  output fbpa_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_ADDR  = 6'b000100,
    S_DIV   = 6'b001000,
    S_CHECK = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = (operation == fbpa_pkg::OP_FREE) ? S_DIV : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.n_zero) begin
          state_next = S_DONE;
        end else if (stat.cur_free) begin
          cmd.claim  = 1'b1;
          state_next = S_ADDR;
        end else if (stat.scan_last) begin
          state_next = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_ADDR: begin
        cmd.set_addr = 1'b1;
        state_next   = S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.commit_free = 1'b1;
        state_next      = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

@@ hw/rtl/fbpa_dp.sv @@
// ----------------------------------------------------------------------------
// fbpa_dp
// Datapath of the allocator: configuration, in-use map, next-fit pointer,
// scan pointer, restoring divider and result registers.
// ----------------------------------------------------------------------------
module fbpa_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  fbpa_pkg::req_t                     request,
  input  logic                               cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fbpa_pkg::ADDR_W-1:0]        cfg_data,
  input  fbpa_pkg::cmd_t                     cmd,
  output fbpa_pkg::stat_t                    stat,
  output fbpa_pkg::res_t                     result
);

  // Configuration
  logic [fbpa_pkg::ADDR_W-1:0] pool_base;
  logic [fbpa_pkg::SIZE_W-1:0] block_size;
  logic [fbpa_pkg::BCNT_W-1:0] block_count;

  // Allocator state
  logic [fbpa_pkg::MAX_BLOCKS-1:0] in_use;
  logic [fbpa_pkg::IDX_W-1:0]      next_index;

  // Per-request working registers
  logic [fbpa_pkg::IDX_W-1:0]                     scan_idx;
  logic [fbpa_pkg::CNT_W-1:0]                     scan_cnt;
  logic [fbpa_pkg::IDX_W+fbpa_pkg::SIZE_W-1:0]    prod;
  logic [fbpa_pkg::ADDR_W-1:0]                    dq;
  logic [fbpa_pkg::SIZE_W-1:0]                    rem;
  logic [fbpa_pkg::DIV_CNT_W-1:0]                 div_cnt;
  logic                                           off_zero;

  // Result registers
  logic                        res_ok;
  logic [fbpa_pkg::ADDR_W-1:0] res_addr;
  logic [fbpa_pkg::IDX_W-1:0]  res_idx;

  logic [fbpa_pkg::CNT_W-1:0]  eff_n;
  logic [fbpa_pkg::CNT_W-1:0]  scan_inc;
  logic [fbpa_pkg::IDX_W-1:0]  scan_adv;
  logic [fbpa_pkg::IDX_W-1:0]  start_idx;
  logic [fbpa_pkg::ADDR_W-1:0] offset;
  logic [fbpa_pkg::SIZE_W:0]   trial;
  logic                        trial_ge;
  logic                        size_zero;
  logic                        quot_in_range;
  logic                        free_valid;
  logic [fbpa_pkg::IDX_W-1:0]  free_idx;
  logic                        free_ok;

  // Clamp the block count to the built capacity
  assign eff_n = (32'(block_count) > 32'(fbpa_pkg::MAX_BLOCKS))
               ? fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS)
               : fbpa_pkg::CNT_W'(block_count);

  // Next-fit pointer step with wrap to block zero
  assign scan_inc  = fbpa_pkg::CNT_W'(scan_idx) + 1'b1;
  assign scan_adv  = (scan_inc >= eff_n) ? '0 : fbpa_pkg::IDX_W'(scan_inc);
  assign start_idx = (fbpa_pkg::CNT_W'(next_index) < eff_n) ? next_index : '0;

  // Divider trial subtract
  assign offset   = request.free_address - pool_base;
  assign trial    = {rem, dq[fbpa_pkg::ADDR_W-1]};
  assign trial_ge = (trial >= {1'b0, block_size});

  // Free validity from the quotient and remainder
  assign size_zero     = (block_size == '0);
  assign quot_in_range = ((dq >> fbpa_pkg::CNT_W) == '0) &&
                         (dq[fbpa_pkg::CNT_W-1:0] < eff_n);
  assign free_valid    = size_zero ? off_zero : ((rem == '0) && quot_in_range);
  assign free_idx      = size_zero ? '0 : dq[fbpa_pkg::IDX_W-1:0];
  assign free_ok       = !stat.n_zero && free_valid && in_use[free_idx];

  // Status to controller
  assign stat.n_zero    = (eff_n == '0);
  assign stat.cur_free  = !in_use[scan_idx];
  assign stat.scan_last = ((scan_cnt + 1'b1) == eff_n);
  assign stat.div_last  = (div_cnt == '1);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base   <= fbpa_pkg::POOL_BASE_RST;
      block_size  <= fbpa_pkg::BLOCK_SIZE_RST;
      block_count <= fbpa_pkg::BLOCK_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fbpa_pkg::CFG_POOL_BASE:   pool_base   <= cfg_data;
        fbpa_pkg::CFG_BLOCK_SIZE:  block_size  <= cfg_data[fbpa_pkg::SIZE_W-1:0];
        fbpa_pkg::CFG_BLOCK_COUNT: block_count <= cfg_data[fbpa_pkg::BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // In-use map and next-fit pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use     <= '0;
      next_index <= '0;
    end else if (cmd.claim) begin
      in_use[scan_idx] <= 1'b1;
      next_index       <= scan_adv;
    end else if (cmd.commit_free && free_ok) begin
      in_use[free_idx] <= 1'b0;
      next_index       <= free_idx;
    end
  end

  // Scan pointer, divider and results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_idx <= start_idx;
      scan_cnt <= '0;
      dq       <= offset;
      rem      <= '0;
      div_cnt  <= '0;
      off_zero <= (offset == '0);
      res_ok   <= 1'b0;
      res_addr <= '0;
      res_idx  <= '0;
    end
    if (cmd.scan_step) begin
      scan_idx <= scan_adv;
      scan_cnt <= scan_cnt + 1'b1;
    end
    if (cmd.claim) begin
      prod    <= scan_idx * block_size;
      res_idx <= scan_idx;
    end
    if (cmd.set_addr) begin
      res_ok   <= 1'b1;
      res_addr <= pool_base + fbpa_pkg::ADDR_W'(prod);
    end
    if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
      if (trial_ge) begin
        rem <= fbpa_pkg::SIZE_W'(trial - {1'b0, block_size});
        dq  <= {dq[fbpa_pkg::ADDR_W-2:0], 1'b1};
      end else begin
        rem <= trial[fbpa_pkg::SIZE_W-1:0];
        dq  <= {dq[fbpa_pkg::ADDR_W-2:0], 1'b0};
      end
    end
    if (cmd.commit_free && free_ok) begin
      res_ok  <= 1'b1;
      res_idx <= free_idx;
    end
  end

  assign result.success       = res_ok;
  assign result.block_address = res_addr;
  assign result.block_index   = fbpa_pkg::BIDX_W'(res_idx);

endmodule

@@ hw/rtl/fixed_block_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Next-fit allocator over a pool of equal-size blocks.
// ----------------------------------------------------------------------------
// Raise start with a request while busy is low; the request transfers at that
// edge and busy rises. Exactly one result follows, shown for one cycle with
// done high, and must be taken then. An allocate walks the in-use map one
// block per cycle from the next-fit pointer, claims the first free block and
// then forms its address; when every block is full the scan ends in a
// failed result, and when the block count is zero the scan state goes
// straight to done. A free turns the address offset into a block index with
// a one-bit-per-cycle restoring divider, then checks the index and commits a
// valid free. busy falls the cycle after done. Configuration writes are taken
// at any time but are meant for an idle block.
module fixed_block_pool_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  fbpa_pkg::req_t                 request,
  output logic                           busy,
  output logic                           done,
  output fbpa_pkg::res_t                 result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbpa_pkg::ADDR_W-1:0]    cfg_data
);

  fbpa_pkg::cmd_t  cmd;
  fbpa_pkg::stat_t stat;

  // Configuration is always accepted
  assign cfg_ready = 1'b1;

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (request.operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  fbpa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule

@@ hw/rtl/fbpa_checker.sv @@
// ----------------------------------------------------------------------------
// fbpa_sva
// Port-level checks of the allocator's request and result sequencing.
// ----------------------------------------------------------------------------
module fbpa_sva (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input fbpa_pkg::res_t result
);

  // A transfer makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after request transfer");

  // A result only appears while busy
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe while idle");

  // Result strobe lasts one cycle and the block then goes idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe not followed by idle");

  // Failed results carry zero address and index
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.success |-> result.block_address == '0 && result.block_index == '0)
    else $error("failed result with nonzero payload");

endmodule

bind fixed_block_pool_allocator fbpa_sva u_fbpa_sva (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

@@ tb/sv/fbpa_checker.sv @@
// ----------------------------------------------------------------------------
// fbpa_checker
// Watches the request, result and configuration channels of the allocator,
// keeps its own copy of the in-use map, next-fit pointer and pool settings,
// predicts the outcome of every accepted request and compares each result
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module fbpa_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  fbpa_pkg::req_t                 request,
  input  logic                           done,
  input  fbpa_pkg::res_t                 result,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbpa_pkg::ADDR_W-1:0]    cfg_data,
  output int                             mismatches,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import fbpa_pkg::*;

  // Mirror of the pool settings and allocator state
  logic [ADDR_W-1:0]     pool_base;
  logic [SIZE_W-1:0]     blk_size;
  logic [BCNT_W-1:0]     blk_count;
  logic [MAX_BLOCKS-1:0] in_use;
  int unsigned           next_fit;

  res_t predicted_outcomes[$];

  // Apply one request to the mirrored pool and return its outcome
  function automatic res_t pool_step(req_t r);
    res_t        o;
    int unsigned n;
    int unsigned idx;
    int unsigned k;
    logic [31:0] off;
    logic        valid;
    logic        found;
    o = '0;
    n = (blk_count > MAX_BLOCKS) ? MAX_BLOCKS : blk_count;
    if (r.operation == OP_ALLOC) begin
      if (n > 0) begin
        idx = (next_fit < n) ? next_fit : 0;
        found = 1'b0;
        for (k = 0; k < n && !found; k++) begin
          if (!in_use[idx]) begin
            in_use[idx] = 1'b1;
            next_fit = (idx + 1 >= n) ? 0 : idx + 1;
            o.success = 1'b1;
            o.block_address = pool_base + 32'(idx) * 32'(blk_size);
            o.block_index = idx[BIDX_W-1:0];
            found = 1'b1;
          end else begin
            idx = (idx + 1 >= n) ? 0 : idx + 1;
          end
        end
      end
    end else begin
      off = r.free_address - pool_base;
      valid = 1'b0;
      idx = 0;
      if (n > 0) begin
        if (blk_size == 0) begin
          valid = (off == 0);
        end else if (64'(off) < 64'(blk_size) * 64'(n) && (off % 32'(blk_size)) == 0) begin
          valid = 1'b1;
          idx = off / 32'(blk_size);
        end
      end
      // Reject a double free and anything outside the live pool
      if (valid && idx < n && idx < MAX_BLOCKS && in_use[idx]) begin
        in_use[idx] = 1'b0;
        next_fit = idx;
        o.success = 1'b1;
        o.block_index = idx[BIDX_W-1:0];
      end
    end
    return o;
  endfunction

  // Report the first few failures in detail, count the rest
  task automatic note_failure(string what, res_t want, res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected ok=%0b addr=%h idx=%0d, got ok=%0b addr=%h idx=%0d",
               $realtime, what, want.success, want.block_address, want.block_index,
               got.success, got.block_address, got.block_index);
  endtask

  // Track settings, predict on each request transfer, compare on each result
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      pool_base = POOL_BASE_RST;
      blk_size = BLOCK_SIZE_RST;
      blk_count = BLOCK_COUNT_RST;
      in_use = '0;
      next_fit = 0;
      predicted_outcomes.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POOL_BASE:   pool_base = cfg_data;
          CFG_BLOCK_SIZE:  blk_size = cfg_data[SIZE_W-1:0];
          CFG_BLOCK_COUNT: blk_count = cfg_data[BCNT_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy)
        predicted_outcomes.push_back(pool_step(request));
      if (done) begin
        if (predicted_outcomes.size() == 0) begin
          note_failure("unexpected result", '0, result);
        end else begin
          want = predicted_outcomes.pop_front();
          if (result.success !== want.success ||
              result.block_address !== want.block_address ||
              result.block_index !== want.block_index)
            note_failure("result mismatch", want, result);
        end
      end
    end
    pending = predicted_outcomes.size();
  end

endmodule

@@ tb/sv/fixed_block_pool_allocator_tb.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_tb
// Drives allocate and free requests into the block pool allocator under
// several pool settings: a directed pass over full pools, double and
// misaligned frees, out-of-range pointers, address wrap, zero size and
// zero count, then randomized traffic with varying sender gaps. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fbpa_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SEGMENTS      = 8;
  localparam int SEGMENT_ITEMS = 150;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  req_t                 request = '0;
  logic                 busy;
  logic                 done;
  res_t                 result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_POOL_BASE;
  logic [ADDR_W-1:0]    cfg_data = '0;

  int mismatches;
  int pending;
  int cycle_count = 0;
  int idle_pct = 0;
  int alloc_pct = 45;

  // Pool settings as last programmed, used to aim frees at real blocks
  logic [31:0] cur_base = POOL_BASE_RST;
  logic [31:0] cur_size = 32'(BLOCK_SIZE_RST);
  logic [31:0] cur_count = 32'(BLOCK_COUNT_RST);

  fixed_block_pool_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fbpa_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic req_t req(logic op, logic [31:0] addr);
    req_t r;
    r.operation = op;
    r.free_address = addr;
    return r;
  endfunction

  // Present one request at a falling edge and hold it until it transfers
  task automatic issue(req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Hold off until every predicted result has come and the block is idle
  task automatic drain();
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
  endtask

  // Write all three pool registers on the configuration channel
  task automatic program_pool(logic [31:0] base, logic [31:0] size, logic [31:0] count);
    logic [31:0] vals[3];
    logic [CFG_IDX_W-1:0] idxs[3];
    vals = '{base, size, count};
    idxs = '{CFG_POOL_BASE, CFG_BLOCK_SIZE, CFG_BLOCK_COUNT};
    for (int k = 0; k < 3; k++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idxs[k];
      cfg_data <= vals[k];
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_base = base;
    cur_size = size & 32'h1FFFF;
    cur_count = count & 32'h7F;
  endtask

  // Mostly allocates and frees of real block addresses, some noise
  function automatic req_t random_item();
    req_t        r;
    int unsigned n;
    int unsigned idx;
    int unsigned pick;
    n = (cur_count > MAX_BLOCKS) ? MAX_BLOCKS : cur_count;
    idx = $urandom_range((n == 0) ? 0 : n - 1);
    pick = $urandom_range(99);
    r.operation = OP_FREE;
    r.free_address = $urandom();
    if (pick < alloc_pct) begin
      r.operation = OP_ALLOC;
    end else if (pick < 88) begin
      r.free_address = cur_base + idx * cur_size;
    end else begin
      case ($urandom_range(3))
        0: ;
        1: r.free_address = cur_base + idx * cur_size + 1;
        2: r.free_address = cur_base + n * cur_size;
        default: r.free_address = cur_base - cur_size;
      endcase
    end
    return r;
  endfunction

  initial begin
    logic [31:0] size_pick;
    logic [31:0] count_pick;
    int idle_plan[3];
    idle_plan = '{0, 45, 17};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: default pool, aligned, double, misaligned and out-of-range frees
    issue(req(OP_ALLOC, 32'h0));
    issue(req(OP_ALLOC, 32'hFFFF_FFFF));
    issue(req(OP_FREE, 32'h10));
    issue(req(OP_FREE, 32'h10));
    issue(req(OP_FREE, 32'h8));
    issue(req(OP_FREE, 32'h400));
    issue(req(OP_FREE, 32'hFFFF_FFFF));
    issue(req(OP_ALLOC, 32'h0));

    // Two blocks, both taken, pointer beyond the count
    drain();
    program_pool(32'h0, 32'd16, 32'd2);
    issue(req(OP_ALLOC, 32'h0));
    issue(req(OP_FREE, 32'h0));
    issue(req(OP_ALLOC, 32'h0));

    // Count above capacity, 64 KiB blocks, addresses wrapping past the top
    drain();
    program_pool(32'hFFFF_FFF0, 32'h1_0000, 32'd127);
    issue(req(OP_ALLOC, 32'h0));
    issue(req(OP_FREE, 32'h003E_FFF0));
    issue(req(OP_FREE, 32'h0001_FFF0));
    issue(req(OP_FREE, 32'h0000_0000));

    // Zero count, then zero size with a few blocks
    drain();
    program_pool(32'h1234_5678, 32'd0, 32'd0);
    issue(req(OP_ALLOC, 32'h0));
    issue(req(OP_FREE, 32'h1234_5678));
    drain();
    program_pool(32'h1234_5678, 32'd0, 32'd5);
    issue(req(OP_FREE, 32'h1234_5678));
    issue(req(OP_FREE, 32'h1234_5678));
    issue(req(OP_FREE, 32'h1234_5679));
    issue(req(OP_ALLOC, 32'h0));
    issue(req(OP_ALLOC, 32'h0));

    // Random traffic, one pool setting and gap profile per segment
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain();
      case (seg)
        0: program_pool(32'h0, 32'd1, 32'd64);
        1: program_pool(32'hFFFF_FFFF, 32'h1_0000, 32'd1);
        2: program_pool($urandom(), $urandom_range(1, 64), 32'd127);
        default: begin
          case ($urandom_range(7))
            0:       size_pick = 32'd0;
            1:       size_pick = 32'h1_0000;
            2, 3:    size_pick = $urandom_range(1, 32'h1_0000);
            default: size_pick = $urandom_range(1, 64);
          endcase
          case ($urandom_range(9))
            0:       count_pick = $urandom_range(65, 127);
            1:       count_pick = $urandom_range(1, 3);
            2, 3:    count_pick = 32'd64;
            default: count_pick = $urandom_range(1, 64);
          endcase
          program_pool($urandom(), size_pick, count_pick);
        end
      endcase
      idle_pct = idle_plan[seg % 3];
      alloc_pct = $urandom_range(30, 55);
      for (int i = 0; i < SEGMENT_ITEMS; i++) begin
        if (seg == 3 && i == SEGMENT_ITEMS / 2)
          drain();
        issue(random_item());
      end
    end

    // Let the last results arrive, then settle
    drain();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_ctrl.sv
hw/rtl/fbpa_dp.sv
hw/rtl/fixed_block_pool_allocator.sv
hw/rtl/fbpa_checker.sv
tb/sv/fbpa_checker.sv
tb/sv/fixed_block_pool_allocator_tb.sv
